// ===== rtl/mipds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mipds_pkg;

  // Geometry limits.
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 12;
  localparam int DIM_W       = 13;

  // Configuration register indexes.
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  // Horizontal pair sum of two pixels: channel sums and the sum of the
  // two linear alpha values. Packed with red in the lowest bits.
  typedef struct packed {
    logic [16:0] a;
    logic [8:0]  b;
    logic [8:0]  g;
    logic [8:0]  r;
  } pair_t;

  // One quad ready for finishing: two row pair sums and the frame-end flag.
  typedef struct packed {
    pair_t s;
    pair_t t;
    logic  last;
  } quad_t;

  typedef logic [255:0][15:0] gt_table_t;

  // Builds round(65535 * (a/255)^2.2) exactly in integer arithmetic: the
  // entry is the largest n with (2n-1)^5 * 255^6 <= 32 * 257^5 * a^11.
  // Evaluated once at elaboration.
  function automatic gt_table_t build_gt_table();
    gt_table_t    tbl;
    logic [159:0] rhs;
    logic [159:0] lhs;
    logic [15:0]  n;
    logic [15:0]  cand;
    logic [16:0]  odd;
    for (int a = 0; a < 256; a++) begin
      rhs = 160'd32;
      for (int k = 0; k < 5; k++) rhs = rhs * 160'd257;
      for (int k = 0; k < 11; k++) rhs = rhs * 160'(a);
      n = '0;
      for (int bit_i = 15; bit_i >= 0; bit_i--) begin
        cand = n | (16'd1 << bit_i);
        odd  = {cand, 1'b0} - 17'd1;
        lhs  = 160'(odd);
        for (int k = 0; k < 4; k++) lhs = lhs * 160'(odd);
        for (int k = 0; k < 6; k++) lhs = lhs * 160'd255;
        if (lhs <= rhs) n = cand;
      end
      tbl[a] = n;
    end
    return tbl;
  endfunction

  localparam gt_table_t GT_TABLE = build_gt_table();

  function automatic pair_t pack_pixel(logic [31:0] p);
    pair_t v;
    v.r = {1'b0, p[7:0]};
    v.g = {1'b0, p[15:8]};
    v.b = {1'b0, p[23:16]};
    v.a = {1'b0, GT_TABLE[p[31:24]]};
    return v;
  endfunction

  function automatic pair_t add_pairs(pair_t x, pair_t y);
    pair_t v;
    v.r = x.r + y.r;
    v.g = x.g + y.g;
    v.b = x.b + y.b;
    v.a = x.a + y.a;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mipds_quad_finish.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mipds_quad_finish (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              quad_valid,
  output logic                   quad_ready,
  input  wire mipds_pkg::quad_t  quad,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata,
  output logic                   out_tlast
);

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] mean;
    logic [3:0]  alpha_hi;
    logic        last;
  } mean_t;

  logic        s2_v_r;
  mean_t       s2_r;
  mean_t       s2_nxt;
  logic        out_v_r;
  logic [31:0] out_pixel_r;
  logic [31:0] out_pixel_nxt;
  logic        out_last_r;
  logic        out_free;
  logic        s2_rdy;

  logic [9:0]  r_sum;
  logic [9:0]  g_sum;
  logic [9:0]  b_sum;
  logic [17:0] a_sum;

  assign out_free   = !out_v_r || out_tready;
  assign s2_rdy     = !s2_v_r || out_free;
  assign quad_ready = s2_rdy;

  assign r_sum = {1'b0, quad.s.r} + {1'b0, quad.t.r};
  assign g_sum = {1'b0, quad.s.g} + {1'b0, quad.t.g};
  assign b_sum = {1'b0, quad.s.b} + {1'b0, quad.t.b};
  assign a_sum = {1'b0, quad.s.a} + {1'b0, quad.t.a};

  // The table rises monotonically, so the alpha count is the largest index
  // whose entry does not exceed the mean. The upper four bits are found here.
  always_comb begin : hi_search
    logic [7:0] j;
    logic [7:0] cand;
    j = 8'h00;
    for (int bit_i = 7; bit_i >= 4; bit_i--) begin
      cand = j | (8'd1 << bit_i);
      if (mipds_pkg::GT_TABLE[cand] <= a_sum[17:2]) j = cand;
    end
    s2_nxt.r        = r_sum[9:2];
    s2_nxt.g        = g_sum[9:2];
    s2_nxt.b        = b_sum[9:2];
    s2_nxt.mean     = a_sum[17:2];
    s2_nxt.alpha_hi = j[7:4];
    s2_nxt.last     = quad.last;
  end

  // The lower four bits of the count.
  always_comb begin : lo_search
    logic [7:0] j;
    logic [7:0] cand;
    j = {s2_r.alpha_hi, 4'h0};
    for (int bit_i = 3; bit_i >= 0; bit_i--) begin
      cand = j | (8'd1 << bit_i);
      if (mipds_pkg::GT_TABLE[cand] <= s2_r.mean) j = cand;
    end
    out_pixel_nxt = {j, s2_r.b, s2_r.g, s2_r.r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_v_r <= quad_valid;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quad_valid && s2_rdy) begin
      s2_r <= s2_nxt;
    end
    if (s2_v_r && out_free) begin
      out_pixel_r <= out_pixel_nxt;
      out_last_r  <= s2_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_free |=> s2_v_r && $stable(s2_r))
    else $error("middle stage changed while stalled");

  a_hi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> mipds_pkg::GT_TABLE[{s2_r.alpha_hi, 4'h0}] <= s2_r.mean)
    else $error("upper alpha search overshot the mean");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r && $stable(out_pixel_r) && $stable(out_last_r))
    else $error("output request changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/mip_downsample_gamma_alpha.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Request contents
// -------   ---------  ------------------------------------------------------
// cfg_*     in         register write: index 0 src_width, 1 src_height
// in_*      in         one source RGBA8 pixel, raster order
// out_*     out        one mip pixel per 2x2 quad, tlast on the frame's last
//
// One source pixel is accepted per cycle, sustained until an output stall
// drops in_tready. A mip pixel appears on out_tvalid once the request
// completing its quad has passed three registers: the input stage register,
// the mean stage and the output register. The line store has no clearing
// pass; reset and every register write restart the frame at once. A stall
// on the output fills the pipeline bubbles first and holds in_tready low
// only once all three stages hold a result.

module mip_downsample_gamma_alpha (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // in_pixel [31:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_pixel [31:0]
  output logic             out_tlast   // last
);

  localparam int AW = mipds_pkg::ADDR_W;
  localparam int CW = mipds_pkg::CNT_W;
  localparam int DW = mipds_pkg::DIM_W;

  // Configuration and position state.
  logic [DW-1:0] src_width_r;
  logic [DW-1:0] src_height_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic [CW-1:0] row_r;
  logic [CW-1:0] row_nxt;
  logic [31:0]   held_r;

  // Effective geometry: a zero dimension acts as one, a large one saturates.
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;
  logic [CW-1:0] dw;
  logic [CW-1:0] dh;
  logic          w_one;
  logic          h_one;

  logic [CW-1:0] x;
  logic [CW-1:0] y;
  logic          in_acc;
  logic          have;
  logic [AW-1:0] ox;
  logic          y_in;
  logic          emit;
  logic          st_we;
  logic          st_re;
  logic          last;
  mipds_pkg::pair_t pair;

  // Line store of even-row pair sums.
  mipds_pkg::pair_t store_mem [mipds_pkg::STORE_DEPTH];
  mipds_pkg::pair_t store_rd_r;

  // Input stage register.
  logic             s1_v_r;
  mipds_pkg::pair_t s1_pair_r;
  logic             s1_self_r;
  logic             s1_last_r;
  logic             quad_ready;
  mipds_pkg::quad_t quad;

  assign w_eff = (src_width_r == '0) ? DW'(1) :
                 (src_width_r > DW'(mipds_pkg::MAX_WIDTH)) ? DW'(mipds_pkg::MAX_WIDTH) :
                 src_width_r;
  assign h_eff = (src_height_r == '0) ? DW'(1) :
                 (src_height_r > DW'(mipds_pkg::MAX_HEIGHT)) ? DW'(mipds_pkg::MAX_HEIGHT) :
                 src_height_r;
  assign w_one = (w_eff == DW'(1));
  assign h_one = (h_eff == DW'(1));
  assign dw    = w_one ? CW'(1) : w_eff[DW-1:1];
  assign dh    = h_one ? CW'(1) : h_eff[DW-1:1];

  // A position outside the frame restarts at the origin.
  always_comb begin
    if (({1'b0, col_r} >= w_eff) || ({1'b0, row_r} >= h_eff)) begin
      x = '0;
      y = '0;
    end else begin
      x = col_r;
      y = row_r;
    end
  end

  assign in_tready = !s1_v_r || quad_ready;
  assign in_acc    = in_tvalid && in_tready;

  // Horizontal pairing. A single column pairs with itself; the odd last
  // column of a wider frame is consumed without a result.
  always_comb begin
    have = 1'b0;
    ox   = '0;
    pair = mipds_pkg::add_pairs(mipds_pkg::pack_pixel(held_r),
                                mipds_pkg::pack_pixel(in_tdata));
    if (w_one) begin
      have = 1'b1;
      pair = mipds_pkg::add_pairs(mipds_pkg::pack_pixel(in_tdata),
                                  mipds_pkg::pack_pixel(in_tdata));
    end else if (({1'b0, x} < {dw, 1'b0}) && x[0]) begin
      have = 1'b1;
      ox   = x[CW-1:1];
    end
  end

  // Vertical pairing. Even rows fill the line store, odd rows finish the
  // quad against it; a single row pairs with itself.
  assign y_in  = ({1'b0, y} < {dh, 1'b0});
  assign st_we = in_acc && have && !h_one && y_in && !y[0];
  assign st_re = in_acc && have && !h_one && y_in && y[0];
  assign emit  = have && (h_one || (y_in && y[0]));
  assign last  = ({1'b0, ox} == (dw - CW'(1))) &&
                 ({1'b0, y[CW-1:1]} == (dh - CW'(1)));

  always_comb begin
    col_nxt = x + CW'(1);
    row_nxt = y;
    if (({1'b0, x} + DW'(1)) >= w_eff) begin
      col_nxt = '0;
      row_nxt = y + CW'(1);
      if (({1'b0, y} + DW'(1)) >= h_eff) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DW'(1);
      src_height_r <= DW'(1);
      col_r        <= '0;
      row_r        <= '0;
      held_r       <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_acc && emit;
      end
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (!w_one && !x[0]) begin
          held_r <= in_tdata;
        end
      end
      // Every register write restarts the frame.
      if (cfg_wr_en) begin
        unique case (cfg_index)
          mipds_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
          mipds_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
          default: ;
        endcase
        col_r  <= '0;
        row_r  <= '0;
        held_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[ox] <= pair;
    end
    if (st_re) begin
      store_rd_r <= store_mem[ox];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pair_r <= pair;
      s1_self_r <= h_one;
      s1_last_r <= last;
    end
  end

  assign quad.s    = s1_self_r ? s1_pair_r : store_rd_r;
  assign quad.t    = s1_pair_r;
  assign quad.last = s1_last_r;

  mipds_quad_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad_valid (s1_v_r),
    .quad_ready (quad_ready),
    .quad       (quad),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < w_eff)
    else $error("column counter left the frame");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < h_eff)
    else $error("row counter left the frame");

  a_store_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_we && st_re))
    else $error("line store written and read by one request");
`endif

endmodule

`default_nettype wire
